FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/mart_pkg.sv
`default_nettype none
package mart_pkg;

   // field widths
   localparam int OP_W          = 2;
   localparam int ADDRESS_W     = 48;
   localparam int CLIENT_ID_W   = 4;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_INDEX_W = 6;
   localparam int CHANGE_W      = 2;
   localparam int TOTAL_W       = 7;
   localparam int REF_W         = 16;
   localparam int KIND_W        = 2;

   // parameter defaults
   localparam int ENTRIES_DEF     = 64;
   localparam int CLIENTS_DEF     = 16;
   localparam int CLIENT_BITS_DEF = 64;
   localparam int ADDR_BITS_DEF   = 48;

   localparam logic [REF_W-1:0] REF_MAX = '1;

   // opcodes
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL        = 2'd2;

   // filter change codes
   localparam logic [CHANGE_W-1:0] CHG_NONE    = 2'd0;
   localparam logic [CHANGE_W-1:0] CHG_ENABLE  = 2'd1;
   localparam logic [CHANGE_W-1:0] CHG_DISABLE = 2'd2;

   // token kinds (opcode already qualified by multicast support)
   localparam logic [KIND_W-1:0] K_ADD  = 2'd0;
   localparam logic [KIND_W-1:0] K_REM  = 2'd1;
   localparam logic [KIND_W-1:0] K_LOOK = 2'd2;
   localparam logic [KIND_W-1:0] K_NONE = 2'd3;

   // CSR map
   localparam int               CSR_ADDR_W       = 3;
   localparam int               CSR_DATA_W       = 32;
   localparam logic [0:0]       REG_MC_SUPPORTED = 1'b0;

   typedef struct packed {
      logic [OP_W-1:0]        op;
      logic [ADDRESS_W-1:0]   address;
      logic [CLIENT_ID_W-1:0] client_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic                     active;
      logic [CHANGE_W-1:0]      filter_change;
      logic [ADDRESS_W-1:0]     change_address;
      logic [TOTAL_W-1:0]       active_total;
      logic [TOTAL_W-1:0]       client_total;
   } rsp_type;

   // search token control, handed cell to cell
   typedef struct packed {
      logic                 valid;
      logic [KIND_W-1:0]    kind;
      logic                 found;
      logic [CHANGE_W-1:0]  change;
      logic                 active;
      logic                 mem_set;
      logic                 mem_clr;
   } tok_ctrl_type;

endpackage
`default_nettype wire

FILE: rtl/mart_cell.sv
`default_nettype none
module mart_cell
   import mart_pkg::*;
#(
   parameter int KEY_W       = ADDR_BITS_DEF,
   parameter int IDX_W       = 6,
   parameter int CLIENTS     = CLIENTS_DEF,
   parameter int CELL_IDX    = 0,
   parameter bit HAS_MEMBERS = 1'b1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tok_ctrl_type       tin_ctrl,
   input  wire logic [KEY_W-1:0]   tin_key,
   input  wire logic [IDX_W-1:0]   tin_idx,
   input  wire logic [CLIENTS-1:0] tin_oh,
   output tok_ctrl_type            tout_ctrl,
   output logic [KEY_W-1:0]        tout_key,
   output logic [IDX_W-1:0]        tout_idx,
   output logic [CLIENTS-1:0]      tout_oh
);

   logic               used_ff, used_in;
   logic [KEY_W-1:0]   addr_ff, addr_in;
   logic [REF_W-1:0]   ref_ff, ref_in;
   tok_ctrl_type       tok_ctrl_ff, tok_ctrl_in;
   logic [KEY_W-1:0]   tok_key_ff;
   logic [IDX_W-1:0]   tok_idx_ff, tok_idx_in;
   logic [CLIENTS-1:0] tok_oh_ff;
   logic               hit, searching;
   logic               mem_ok, mem_hit;
   logic               set_mem, clr_mem;

   assign hit       = used_ff && (addr_ff == tin_key);
   assign searching = tin_ctrl.valid && !tin_ctrl.found;

   // per-client membership bit for this entry, only where it fits the bitmap
   if (HAS_MEMBERS) begin : g_mem
      logic [CLIENTS-1:0] member_ff;
      assign mem_ok  = |tin_oh;
      assign mem_hit = |(member_ff & tin_oh);
      always_ff @(posedge clock) begin
         if (reset) begin
            member_ff <= '0;
         end else if (set_mem) begin
            member_ff <= member_ff | tin_oh;
         end else if (clr_mem) begin
            member_ff <= member_ff & ~tin_oh;
         end
      end
   end else begin : g_nomem
      assign mem_ok  = 1'b0;
      assign mem_hit = 1'b0;
   end

   always_comb begin
      tok_ctrl_in = tin_ctrl;
      tok_idx_in  = tin_idx;
      used_in     = used_ff;
      addr_in     = addr_ff;
      ref_in      = ref_ff;
      set_mem     = 1'b0;
      clr_mem     = 1'b0;
      case (tin_ctrl.kind)
         K_ADD: begin
            // entries fill in order, so the first free cell ends the search
            if (searching && (hit || !used_ff)) begin
               tok_ctrl_in.found = 1'b1;
               tok_idx_in        = IDX_W'(CELL_IDX);
               used_in           = 1'b1;
               addr_in           = tin_key;
               if (ref_ff != REF_MAX) begin
                  ref_in = ref_ff + REF_W'(1);
                  if (ref_ff == '0) begin
                     tok_ctrl_in.change = CHG_ENABLE;
                  end
               end
               if (mem_ok && !mem_hit) begin
                  set_mem             = 1'b1;
                  tok_ctrl_in.mem_set = 1'b1;
               end
            end
         end
         K_REM: begin
            if (searching && hit) begin
               tok_ctrl_in.found = 1'b1;
               tok_idx_in        = IDX_W'(CELL_IDX);
               if (ref_ff != '0) begin
                  ref_in = ref_ff - REF_W'(1);
                  if (ref_ff == REF_W'(1)) begin
                     tok_ctrl_in.change = CHG_DISABLE;
                  end
                  if (mem_hit) begin
                     clr_mem             = 1'b1;
                     tok_ctrl_in.mem_clr = 1'b1;
                  end
               end
            end
         end
         K_LOOK: begin
            if (searching && hit) begin
               tok_ctrl_in.found  = 1'b1;
               tok_idx_in         = IDX_W'(CELL_IDX);
               tok_ctrl_in.active = (ref_ff != '0);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= 1'b0;
         ref_ff      <= '0;
         tok_ctrl_ff <= '0;
      end else begin
         used_ff     <= used_in;
         ref_ff      <= ref_in;
         tok_ctrl_ff <= tok_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      tok_key_ff <= tin_key;
      tok_idx_ff <= tok_idx_in;
      tok_oh_ff  <= tin_oh;
   end

   assign tout_ctrl = tok_ctrl_ff;
   assign tout_key  = tok_key_ff;
   assign tout_idx  = tok_idx_ff;
   assign tout_oh   = tok_oh_ff;

endmodule
`default_nettype wire

FILE: rtl/multicast_address_refcount_table.sv
`default_nettype none
// Multicast address table with per-entry reference counts and per-client
// membership. Each request beat (add, remove, lookup; opcode three acts as a
// lookup) launches a search token into a chain of ENTRIES cells, one cell per
// table entry; the token moves one cell per clock, and the cell that holds
// the address (or, for an add, the first free cell) updates its reference
// count and client membership bits in place. After the last cell a final
// stage updates the global active count and the client's join count and
// loads the response register. One request is in flight at a time:
// req_stall stays high from a beat's acceptance while its token walks the
// cell chain and waits in the final stage for the response register; the
// next request is accepted as soon as the response is loaded, even if that
// response has not yet been taken. There is no
// clearing pass after reset. Register 0 (multicast_supported, reset 1) sits
// at byte address 0 of the CSR port; write it only while the block is idle.
`include "assert_macros.svh"
module multicast_address_refcount_table
   import mart_pkg::*;
#(
   parameter int ENTRIES     = ENTRIES_DEF,
   parameter int CLIENTS     = CLIENTS_DEF,
   parameter int CLIENT_BITS = CLIENT_BITS_DEF,
   parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   // CSR port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   // only the low address bits that fit the field take part in matching
   localparam int KEY_W = (ADDR_BITS < ADDRESS_W) ? ADDR_BITS : ADDRESS_W;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // ---------------------------------------------------------------------
   // CSR: multicast_supported
   // ---------------------------------------------------------------------
   logic mc_ff;
   logic csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_MC_SUPPORTED);
   assign csr_prdata = csr_hit ? CSR_DATA_W'(mc_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mc_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         mc_ff <= csr_pwdata[0];
      end
   end

   // ---------------------------------------------------------------------
   // Launch: accept a beat and inject the search token into cell 0
   // ---------------------------------------------------------------------
   logic               busy_ff;
   logic               req_take;
   tok_ctrl_type       lt_ctrl_ff, lt_ctrl_in;
   logic [KEY_W-1:0]   lt_key_ff;
   logic [CLIENTS-1:0] lt_oh_ff, lt_oh_in;

   assign req_stall = busy_ff;
   assign req_take  = req_valid && !busy_ff;

   always_comb begin
      lt_ctrl_in       = '0;
      lt_ctrl_in.valid = req_take;
      lt_ctrl_in.kind  = K_LOOK;
      lt_ctrl_in.change = CHG_NONE;
      if (req_data.op inside {OP_ADD, OP_REMOVE}) begin
         if (!mc_ff) begin
            lt_ctrl_in.kind = K_NONE;
         end else if (req_data.op == OP_ADD) begin
            lt_ctrl_in.kind = K_ADD;
         end else begin
            lt_ctrl_in.kind = K_REM;
         end
      end
      // one-hot client select; out-of-range ids select nothing
      for (int k = 0; k < CLIENTS; k++) begin
         lt_oh_in[k] = (32'(req_data.client_id) == k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ctrl_ff <= '0;
      end else begin
         lt_ctrl_ff <= lt_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         lt_key_ff <= KEY_W'(req_data.address);
         lt_oh_ff  <= lt_oh_in;
      end
   end

   // ---------------------------------------------------------------------
   // Cell chain: slot 0 is the launch register, slot i+1 is cell i's output
   // ---------------------------------------------------------------------
   tok_ctrl_type       tok_ctrl [0:ENTRIES];
   logic [KEY_W-1:0]   tok_key  [0:ENTRIES];
   logic [IDX_W-1:0]   tok_idx  [0:ENTRIES];
   logic [CLIENTS-1:0] tok_oh   [0:ENTRIES];

   assign tok_ctrl[0] = lt_ctrl_ff;
   assign tok_key[0]  = lt_key_ff;
   assign tok_idx[0]  = '0;
   assign tok_oh[0]   = lt_oh_ff;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      mart_cell #(
         .KEY_W       (KEY_W),
         .IDX_W       (IDX_W),
         .CLIENTS     (CLIENTS),
         .CELL_IDX    (i),
         .HAS_MEMBERS (i < CLIENT_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .tin_ctrl  (tok_ctrl[i]),
         .tin_key   (tok_key[i]),
         .tin_idx   (tok_idx[i]),
         .tin_oh    (tok_oh[i]),
         .tout_ctrl (tok_ctrl[i+1]),
         .tout_key  (tok_key[i+1]),
         .tout_idx  (tok_idx[i+1]),
         .tout_oh   (tok_oh[i+1])
      );
   end

   // ---------------------------------------------------------------------
   // Final stage: hold the exiting token until the response register frees
   // ---------------------------------------------------------------------
   tok_ctrl_type       fin_ctrl_ff;
   logic [KEY_W-1:0]   fin_key_ff;
   logic [IDX_W-1:0]   fin_idx_ff;
   logic [CLIENTS-1:0] fin_oh_ff;
   logic               fin_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ctrl_ff <= '0;
      end else if (tok_ctrl[ENTRIES].valid) begin
         fin_ctrl_ff <= tok_ctrl[ENTRIES];
      end else if (fin_load) begin
         fin_ctrl_ff.valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_ctrl[ENTRIES].valid) begin
         fin_key_ff <= tok_key[ENTRIES];
         fin_idx_ff <= tok_idx[ENTRIES];
         fin_oh_ff  <= tok_oh[ENTRIES];
      end
   end

   // global active count and per-client join counts
   logic [CNT_W-1:0] act_ff, act_in;
   logic [CNT_W-1:0] cnt_ff [CLIENTS];
   logic [CNT_W-1:0] cnt_in [CLIENTS];
   logic [CNT_W-1:0] cnt_sel;

   always_comb begin
      act_in = act_ff;
      if (fin_ctrl_ff.change == CHG_ENABLE) begin
         act_in = act_ff + CNT_W'(1);
      end else if (fin_ctrl_ff.change == CHG_DISABLE && act_ff != '0) begin
         act_in = act_ff - CNT_W'(1);
      end
      cnt_sel = '0;
      for (int k = 0; k < CLIENTS; k++) begin
         cnt_in[k] = cnt_ff[k];
         if (fin_oh_ff[k] && fin_ctrl_ff.mem_set) begin
            cnt_in[k] = cnt_ff[k] + CNT_W'(1);
         end else if (fin_oh_ff[k] && fin_ctrl_ff.mem_clr && cnt_ff[k] != '0) begin
            cnt_in[k] = cnt_ff[k] - CNT_W'(1);
         end
         cnt_sel = cnt_sel | (fin_oh_ff[k] ? cnt_in[k] : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
         for (int k = 0; k < CLIENTS; k++) begin
            cnt_ff[k] <= '0;
         end
      end else if (fin_load) begin
         act_ff <= act_in;
         for (int k = 0; k < CLIENTS; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign fin_load = fin_ctrl_ff.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_in.status = ST_OK;
      if (fin_ctrl_ff.kind == K_NONE) begin
         rsp_in.status = ST_UNSUPPORTED;
      end else if (fin_ctrl_ff.kind == K_ADD && !fin_ctrl_ff.found) begin
         rsp_in.status = ST_FULL;
      end
      rsp_in.entry_index    = ENTRY_INDEX_W'(fin_idx_ff);
      rsp_in.active         = fin_ctrl_ff.active;
      rsp_in.filter_change  = fin_ctrl_ff.change;
      rsp_in.change_address = (fin_ctrl_ff.change != CHG_NONE) ? ADDRESS_W'(fin_key_ff) : '0;
      rsp_in.active_total   = TOTAL_W'(act_in);
      rsp_in.client_total   = TOTAL_W'(cnt_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         if (fin_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_take) begin
            busy_ff <= 1'b1;
         end else if (fin_load) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fin_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `ASSERT_NEXT(a_take_sets_busy, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_IMPLY(a_token_only_when_busy, clock, reset, tok_ctrl[ENTRIES].valid, busy_ff)
   `ASSERT_IMPLY(a_rsp_from_busy, clock, reset, $rose(rsp_valid_ff), $past(busy_ff))
   `ASSERT_IMPLY(a_active_bounded, clock, reset, 1'b1, act_ff <= CNT_W'(ENTRIES))

endmodule
`default_nettype wire
